// ===== hw/rtl/cpg_pkg.sv =====
package cpg_pkg;

    localparam int COMP_BITS      = 21;
    localparam int VEC_BITS       = 3 * COMP_BITS;
    localparam int SCALE_BITS     = 32;
    localparam int FACTOR_BITS    = 32;
    localparam int SCALE_SHIFT    = 40;
    localparam int QUOT_SHIFT     = 40;
    localparam int INDEX_FRAC     = 16;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 64;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_BASIS_ONE      = 4'd0,
        REG_BASIS_TWO      = 4'd1,
        REG_BASIS_THREE    = 4'd2,
        REG_SHIFT_VECTOR   = 4'd3,
        REG_Q_VECTOR       = 4'd4,
        REG_Q_IS_ZERO      = 4'd5,
        REG_LATTICE_SCALE  = 4'd6,
        REG_COULOMB_FACTOR = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0][VEC_BITS-1:0] basis;
        logic [VEC_BITS-1:0]      shift_vec;
        logic [VEC_BITS-1:0]      q_vec;
        logic                     q_is_zero;
        logic [SCALE_BITS-1:0]    lattice_scale;
        logic [FACTOR_BITS-1:0]   coulomb_factor;
    } cfg_t;

endpackage

// ===== hw/rtl/cpg_index_if.sv =====
interface cpg_index_if #(
    parameter int INDEX_BITS = 10
);
    logic                         valid;
    logic                         ready;
    logic signed [INDEX_BITS-1:0] index_x;
    logic signed [INDEX_BITS-1:0] index_y;
    logic signed [INDEX_BITS-1:0] index_z;
    logic                         last_vector;

    modport source (output valid, index_x, index_y, index_z, last_vector, input ready);
    modport sink   (input valid, index_x, index_y, index_z, last_vector, output ready);
endinterface

// ===== hw/rtl/cpg_result_if.sv =====
interface cpg_result_if #(
    parameter int RESULT_BITS = 48
);
    logic                   valid;
    logic                   ready;
    logic [RESULT_BITS-1:0] potential;
    logic                   saturated;
    logic                   last_result;

    modport source (output valid, potential, saturated, last_result, input ready);
    modport sink   (input valid, potential, saturated, last_result, output ready);
endinterface

// ===== hw/rtl/cpg_cfg_if.sv =====
interface cpg_cfg_if
    import cpg_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/cpg_cfg_regs.sv =====
module cpg_cfg_regs
    import cpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    cpg_cfg_if.sink   cfg,
    output cfg_t      regs
);

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '{basis: '0, shift_vec: '0, q_vec: '0, q_is_zero: 1'b1,
                          lattice_scale: '0, coulomb_factor: '0};
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_BASIS_ONE:      regs_reg.basis[0]  <= cfg.data[VEC_BITS-1:0];
                REG_BASIS_TWO:      regs_reg.basis[1]  <= cfg.data[VEC_BITS-1:0];
                REG_BASIS_THREE:    regs_reg.basis[2]  <= cfg.data[VEC_BITS-1:0];
                REG_SHIFT_VECTOR:   regs_reg.shift_vec <= cfg.data[VEC_BITS-1:0];
                REG_Q_VECTOR:       regs_reg.q_vec     <= cfg.data[VEC_BITS-1:0];
                REG_Q_IS_ZERO:      regs_reg.q_is_zero <= cfg.data[0];
                REG_LATTICE_SCALE:  regs_reg.lattice_scale  <= cfg.data[SCALE_BITS-1:0];
                REG_COULOMB_FACTOR: regs_reg.coulomb_factor <= cfg.data[FACTOR_BITS-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/cpg_front.sv =====
module cpg_front
    import cpg_pkg::*;
#(
    parameter int INDEX_BITS = 10,
    parameter int K2_BITS    = 2 * (INDEX_BITS + 33) + 2
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  cfg_t                         cfg,
    input  logic                         in_valid,
    input  logic signed [INDEX_BITS-1:0] in_x,
    input  logic signed [INDEX_BITS-1:0] in_y,
    input  logic signed [INDEX_BITS-1:0] in_z,
    input  logic                         in_last,
    output logic                         out_valid,
    output logic [K2_BITS-1:0]           out_k2,
    output logic                         out_last
);

    localparam int G_BITS    = INDEX_BITS + INDEX_FRAC + 1;
    localparam int PROD_BITS = G_BITS + COMP_BITS;
    localparam int C_BITS    = PROD_BITS + 2;
    localparam int MLO       = 32;
    localparam int MHI       = C_BITS - MLO;
    localparam int P_BITS    = C_BITS + SCALE_BITS + 1;
    localparam int K_BITS    = P_BITS - SCALE_SHIFT;
    localparam int KLO       = 32;
    localparam int KHI       = K_BITS - KLO;
    localparam int SQ_BITS   = 2 * K_BITS;
    localparam int STAGES    = 8;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] last_reg;

    logic signed [G_BITS-1:0]       g_reg    [3];
    logic signed [PROD_BITS-1:0]    prod_reg [3][3];
    logic [C_BITS-1:0]              mag_reg  [3];
    logic [MLO+SCALE_BITS-1:0]      plo_reg  [3];
    logic [MHI+SCALE_BITS-1:0]      phi_reg  [3];
    logic [K_BITS-1:0]              k_reg    [3];
    logic [2*KLO-1:0]               kll_reg  [3];
    logic [KLO+KHI-1:0]             klh_reg  [3];
    logic [2*KHI-1:0]               khh_reg  [3];
    logic [SQ_BITS-1:0]             sq_reg   [3];
    logic [K2_BITS-1:0]             k2_reg;

    logic signed [INDEX_BITS-1:0] n   [3];
    logic [VEC_BITS-1:0]          off_vec;

    assign n[0]    = in_x;
    assign n[1]    = in_y;
    assign n[2]    = in_z;
    assign off_vec = cfg.q_is_zero ? cfg.shift_vec : cfg.q_vec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg <= {last_reg[STAGES-2:0], in_last};
            k2_reg   <= K2_BITS'(sq_reg[0]) + K2_BITS'(sq_reg[1]) + K2_BITS'(sq_reg[2]);
        end
    end

    for (genvar j = 0; j < 3; j++)
    begin : g_lane
        logic signed [C_BITS-1:0]  c_sum;
        logic [P_BITS-1:0]         p_sum;
        logic signed [COMP_BITS-1:0] off_c;

        assign off_c = $signed(off_vec[j*COMP_BITS +: COMP_BITS]);
        assign c_sum = C_BITS'(prod_reg[j][0]) + C_BITS'(prod_reg[j][1])
                     + C_BITS'(prod_reg[j][2]);
        assign p_sum = (P_BITS'(phi_reg[j]) << MLO) + P_BITS'(plo_reg[j])
                     + (P_BITS'(1) << (SCALE_SHIFT - 1));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                // offset-added index in Q.16; lane j also holds index j here
                g_reg[j] <= (G_BITS'(n[j]) <<< INDEX_FRAC) + G_BITS'(off_c);
                for (int i = 0; i < 3; i++)
                begin
                    prod_reg[j][i] <= PROD_BITS'(g_reg[i])
                        * PROD_BITS'($signed(cfg.basis[i][j*COMP_BITS +: COMP_BITS]));
                end
                mag_reg[j] <= c_sum[C_BITS-1] ? C_BITS'(-c_sum) : C_BITS'(c_sum);
                plo_reg[j] <= (MLO+SCALE_BITS)'(mag_reg[j][MLO-1:0])
                            * (MLO+SCALE_BITS)'(cfg.lattice_scale);
                phi_reg[j] <= (MHI+SCALE_BITS)'(mag_reg[j][C_BITS-1:MLO])
                            * (MHI+SCALE_BITS)'(cfg.lattice_scale);
                k_reg[j]   <= p_sum[SCALE_SHIFT +: K_BITS];
                kll_reg[j] <= (2*KLO)'(k_reg[j][KLO-1:0]) * (2*KLO)'(k_reg[j][KLO-1:0]);
                klh_reg[j] <= (KLO+KHI)'(k_reg[j][KLO-1:0])
                            * (KLO+KHI)'(k_reg[j][K_BITS-1:KLO]);
                khh_reg[j] <= (2*KHI)'(k_reg[j][K_BITS-1:KLO])
                            * (2*KHI)'(k_reg[j][K_BITS-1:KLO]);
                sq_reg[j]  <= (SQ_BITS'(khh_reg[j]) << (2*KLO))
                            + (SQ_BITS'(klh_reg[j]) << (KLO + 1))
                            + SQ_BITS'(kll_reg[j]);
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_last  = last_reg[STAGES-1];
    assign out_k2    = k2_reg;

endmodule

// ===== hw/rtl/cpg_divider.sv =====
module cpg_divider
    import cpg_pkg::*;
#(
    parameter int K2_BITS     = 88,
    parameter int RESULT_BITS = 48
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic [FACTOR_BITS-1:0] factor,
    input  logic                   in_valid,
    input  logic [K2_BITS-1:0]     in_den,
    input  logic                   in_last,
    output logic                   out_valid,
    output logic [RESULT_BITS-1:0] out_potential,
    output logic                   out_saturated,
    output logic                   out_last
);

    localparam int QUOT_BITS = FACTOR_BITS + QUOT_SHIFT;
    localparam int STEP_BITS = 2;
    localparam int STAGES    = QUOT_BITS / STEP_BITS;
    localparam int REM_BITS  = K2_BITS + 1;

    logic [QUOT_BITS-1:0] dividend;
    logic [STAGES-1:0]    valid_reg;
    logic [STAGES-1:0]    last_reg;
    logic [REM_BITS-1:0]  rem_reg  [STAGES];
    logic [QUOT_BITS-1:0] quot_reg [STAGES];
    logic [K2_BITS-1:0]   den_reg  [STAGES];

    assign dividend = {factor, {QUOT_SHIFT{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg <= {last_reg[STAGES-2:0], in_last};
        end
    end

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [REM_BITS-1:0]  rem_in;
        logic [QUOT_BITS-1:0] quot_in;
        logic [K2_BITS-1:0]   den_in;
        logic [REM_BITS-1:0]  rem_next;
        logic [QUOT_BITS-1:0] quot_next;

        if (s == 0)
        begin : g_first
            assign rem_in  = '0;
            assign quot_in = '0;
            assign den_in  = in_den;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign quot_in = quot_reg[s-1];
            assign den_in  = den_reg[s-1];
        end

        // restoring steps, most significant quotient bit first
        always_comb
        begin
            rem_next  = rem_in;
            quot_next = quot_in;
            for (int b = 0; b < STEP_BITS; b++)
            begin
                rem_next = {rem_next[REM_BITS-2:0],
                            dividend[QUOT_BITS-1-(s*STEP_BITS+b)]};
                if (rem_next >= REM_BITS'(den_in))
                begin
                    rem_next = rem_next - REM_BITS'(den_in);
                    quot_next[QUOT_BITS-1-(s*STEP_BITS+b)] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                quot_reg[s] <= quot_next;
                den_reg[s]  <= den_in;
            end
        end
    end

    assign out_valid     = valid_reg[STAGES-1];
    assign out_last      = last_reg[STAGES-1];
    assign out_saturated = (den_reg[STAGES-1] == '0)
                         || (|quot_reg[STAGES-1][QUOT_BITS-1:RESULT_BITS]);
    assign out_potential = out_saturated ? {RESULT_BITS{1'b1}}
                                         : quot_reg[STAGES-1][RESULT_BITS-1:0];

endmodule

// ===== hw/rtl/coulomb_potential_per_gvector.sv =====
// Bare Coulomb potential per reciprocal-lattice vector. Each request carries a
// signed index triple; the block adds the selected offset (shift vector when
// q_is_zero is set, else q vector), maps it through the three basis vectors,
// scales by lattice_scale, sums the squared components and returns
// coulomb_factor * 2^40 / |k|^2 as unsigned Q24.24, saturated to all ones
// with the saturated flag when the length is zero or the quotient overflows.
// The datapath is a pipeline that accepts one request every cycle while the
// skid entry is free and delivers one result per request in order. A request
// passes eight stages of offset add, basis products, magnitude, scale
// products, rounding, square partials, squares and sum, then 36
// restoring-division stages at two quotient bits each, then the output
// register. A two-entry output buffer (output register plus skid) lets the
// pipe keep accepting while one result waits; the pipe holds only
// once the skid entry is occupied. Configuration is written through a
// separate write channel that is always ready; write only while idle.
module coulomb_potential_per_gvector
    import cpg_pkg::*;
#(
    parameter int INDEX_BITS  = 10,
    parameter int RESULT_BITS = 48
)(
    input  logic          clk,
    input  logic          rst_n,
    cpg_index_if.sink     index_ch,
    cpg_result_if.source  result_ch,
    cpg_cfg_if.sink       cfg
);

    // squared-length width follows from the index width
    localparam int K_BITS  = INDEX_BITS + INDEX_FRAC + 1 + COMP_BITS + 2 + SCALE_BITS
                           + 1 - SCALE_SHIFT;
    localparam int K2_BITS = 2 * K_BITS + 2;

    cfg_t regs;

    logic                   en;
    logic                   k2_valid;
    logic [K2_BITS-1:0]     k2;
    logic                   k2_last;
    logic                   p_valid;
    logic [RESULT_BITS-1:0] p_potential;
    logic                   p_saturated;
    logic                   p_last;

    logic                   out_valid_reg;
    logic [RESULT_BITS-1:0] out_potential_reg;
    logic                   out_saturated_reg;
    logic                   out_last_reg;
    logic                   skid_valid_reg;
    logic [RESULT_BITS-1:0] skid_potential_reg;
    logic                   skid_saturated_reg;
    logic                   skid_last_reg;
    logic                   out_take;

    cpg_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // advance the whole pipe unless the skid entry is holding a result
    assign en             = !skid_valid_reg;
    assign index_ch.ready = en;

    cpg_front #(
        .INDEX_BITS (INDEX_BITS),
        .K2_BITS    (K2_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (regs),
        .in_valid  (index_ch.valid),
        .in_x      (index_ch.index_x),
        .in_y      (index_ch.index_y),
        .in_z      (index_ch.index_z),
        .in_last   (index_ch.last_vector),
        .out_valid (k2_valid),
        .out_k2    (k2),
        .out_last  (k2_last)
    );

    cpg_divider #(
        .K2_BITS     (K2_BITS),
        .RESULT_BITS (RESULT_BITS)
    ) u_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .factor        (regs.coulomb_factor),
        .in_valid      (k2_valid),
        .in_den        (k2),
        .in_last       (k2_last),
        .out_valid     (p_valid),
        .out_potential (p_potential),
        .out_saturated (p_saturated),
        .out_last      (p_last)
    );

    assign out_take = out_valid_reg && result_ch.ready;

    // output register with skid: a result leaving the pipe goes to the
    // output register when that is free or being taken, else into the skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (p_valid && en)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_valid && en)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_potential_reg <= p_potential;
                out_saturated_reg <= p_saturated;
                out_last_reg      <= p_last;
            end
            else
            begin
                skid_potential_reg <= p_potential;
                skid_saturated_reg <= p_saturated;
                skid_last_reg      <= p_last;
            end
        end
        else if (out_take && skid_valid_reg)
        begin
            out_potential_reg <= skid_potential_reg;
            out_saturated_reg <= skid_saturated_reg;
            out_last_reg      <= skid_last_reg;
        end
    end

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.potential   = out_potential_reg;
    assign result_ch.saturated   = out_saturated_reg;
    assign result_ch.last_result = out_last_reg;

endmodule
